/* hw/rtl/q2e_pkg.sv */
// ----------------------------------------------------------------------------
// q2e_pkg: shared types and constants for the quaternion to Euler unit
// Item structs, CORDIC vector type, arctangent table and small helpers.
// ----------------------------------------------------------------------------
package q2e_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_TABLE_LEN    = 24;

  // CORDIC datapath widths: vector grows by about 1.65 over a 34-bit operand
  localparam int XW = 38;
  localparam int ZW = 34;

  // integer square root: 58-bit radicand, one result bit per cell
  localparam int SQRT_STEPS = 29;
  localparam int RAD_W      = 2 * SQRT_STEPS;
  localparam int ROOT_W     = SQRT_STEPS;
  localparam int REM_W      = 31;
  localparam int ACC_W      = REM_W + 2;
  localparam int TW         = 30;

  localparam logic signed [ZW-1:0] HALF_PI   = 34'sd1686629713;
  localparam logic signed [TW-1:0] ONE_Q28   = 30'sd268435456;
  localparam logic signed [15:0]   OUT_LIMIT = 16'sd25736;

  typedef struct packed {
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic signed [15:0] roll_angle;
    logic               pitch_clamped;
  } out_item_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } vec_t;

  // square-root cell payload, with the yaw/roll vectors riding alongside
  typedef struct packed {
    logic [REM_W-1:0]     rem;
    logic [ROOT_W-1:0]    root;
    logic [RAD_W-1:0]     rad;
    logic signed [TW-1:0] t;
    logic                 clamped;
    vec_t                 yaw;
    vec_t                 roll;
  } sqrt_t;

  // atan(2^-i) at scale 2^30
  function automatic logic signed [ZW-1:0] atan_const(input int i);
    logic signed [ZW-1:0] a;
    begin
      unique case (i)
        0:  a = 34'sh03243F6A8;
        1:  a = 34'sh01DAC6705;
        2:  a = 34'sh00FADBAFC;
        3:  a = 34'sh007F56EA6;
        4:  a = 34'sh003FEAB76;
        5:  a = 34'sh001FFD55B;
        6:  a = 34'sh000FFFAAA;
        7:  a = 34'sh0007FFF55;
        8:  a = 34'sh0003FFFEA;
        9:  a = 34'sh0001FFFFD;
        10: a = 34'sh0000FFFFF;
        11: a = 34'sh00007FFFF;
        12: a = 34'sh00003FFFF;
        13: a = 34'sh00001FFFF;
        14: a = 34'sh00000FFFF;
        15: a = 34'sh000007FFF;
        16: a = 34'sh000003FFF;
        17: a = 34'sh000001FFF;
        18: a = 34'sh000000FFF;
        19: a = 34'sh0000007FF;
        20: a = 34'sh0000003FF;
        21: a = 34'sh0000001FF;
        22: a = 34'sh0000000FF;
        23: a = 34'sh00000007F;
        default: a = '0;
      endcase
      return a;
    end
  endfunction

  // fold the left half plane into the right by a quarter turn
  function automatic vec_t pre_rot(input logic signed [XW-1:0] x,
                                   input logic signed [XW-1:0] y);
    vec_t v;
    begin
      v.x = x;
      v.y = y;
      v.z = '0;
      if (x < 0) begin
        if (y >= 0) begin
          v.x = y;
          v.y = -x;
          v.z = HALF_PI;
        end else begin
          v.x = -y;
          v.y = x;
          v.z = -HALF_PI;
        end
      end
      return v;
    end
  endfunction

  // 2^30 angle to Q2.13, ties up, saturated
  function automatic logic signed [15:0] to_q13(input logic signed [ZW-1:0] z);
    logic signed [ZW:0] s;
    logic signed [ZW:0] r;
    begin
      s = (ZW+1)'(z) + (ZW+1)'(65536);
      r = s >>> 17;
      if (r > (ZW+1)'(OUT_LIMIT)) begin
        r = (ZW+1)'(OUT_LIMIT);
      end else if (r < -((ZW+1)'(OUT_LIMIT))) begin
        r = -((ZW+1)'(OUT_LIMIT));
      end
      return 16'(r);
    end
  endfunction

endpackage

/* hw/rtl/q2e_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// q2e_sqrt_cell: one digit of the restoring integer square root
// Takes two radicand bits, produces one root bit, passes the rest along.
// ----------------------------------------------------------------------------
module q2e_sqrt_cell (
  input  logic           clk,
  input  logic           en,
  input  q2e_pkg::sqrt_t sq_i,
  output q2e_pkg::sqrt_t sq_o
);

  logic [q2e_pkg::ACC_W-1:0] acc;
  logic [q2e_pkg::ACC_W-1:0] trial;
  q2e_pkg::sqrt_t            sq_nxt;
  q2e_pkg::sqrt_t            sq_r;

  // trial subtract of (root << 2) | 1
  always_comb begin
    acc    = {sq_i.rem, sq_i.rad[q2e_pkg::RAD_W-1 -: 2]};
    trial  = {2'b00, sq_i.root, 2'b01};
    sq_nxt = sq_i;
    sq_nxt.rad = {sq_i.rad[q2e_pkg::RAD_W-3:0], 2'b00};
    if (acc >= trial) begin
      sq_nxt.rem  = q2e_pkg::REM_W'(acc - trial);
      sq_nxt.root = {sq_i.root[q2e_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      sq_nxt.rem  = q2e_pkg::REM_W'(acc);
      sq_nxt.root = {sq_i.root[q2e_pkg::ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r <= sq_nxt;
    end
  end

  assign sq_o = sq_r;

endmodule

/* hw/rtl/q2e_cordic_cell.sv */
// ----------------------------------------------------------------------------
// q2e_cordic_cell: one vectoring-mode CORDIC micro-rotation
// Drives y toward zero and accumulates the angle; holds once y is zero.
// ----------------------------------------------------------------------------
module q2e_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic          clk,
  input  logic          en,
  input  q2e_pkg::vec_t vec_i,
  output q2e_pkg::vec_t vec_o
);

  logic signed [q2e_pkg::XW-1:0] xs;
  logic signed [q2e_pkg::XW-1:0] ys;
  q2e_pkg::vec_t                 vec_nxt;
  q2e_pkg::vec_t                 vec_r;

  // rotate by -/+ atan(2^-STAGE) according to the sign of y
  always_comb begin
    xs      = vec_i.x >>> STAGE;
    ys      = vec_i.y >>> STAGE;
    vec_nxt = vec_i;
    if (vec_i.y > 0) begin
      vec_nxt.x = vec_i.x + ys;
      vec_nxt.y = vec_i.y - xs;
      vec_nxt.z = vec_i.z + q2e_pkg::atan_const(STAGE);
    end else if (vec_i.y < 0) begin
      vec_nxt.x = vec_i.x - ys;
      vec_nxt.y = vec_i.y + xs;
      vec_nxt.z = vec_i.z - q2e_pkg::atan_const(STAGE);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_r <= vec_nxt;
    end
  end

  assign vec_o = vec_r;

endmodule

/* hw/rtl/quaternion_to_euler_unit.sv */
// ----------------------------------------------------------------------------
// quaternion_to_euler_unit: Q1.14 quaternion to pitch/yaw/roll in Q2.13
// Products, sums, square-root cell row, three CORDIC cell rows, output reg.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle; the whole pipeline advances together and
// holds only while a finished item waits at a stalled output.
// Reset: synchronous, active low; clears all valid bits, payload is not reset.
// ----------------------------------------------------------------------------
module quaternion_to_euler_unit #(
  parameter int CORDIC_STAGES = q2e_pkg::CORDIC_STAGES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  q2e_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output q2e_pkg::out_item_t  out_data
);

  localparam int DEPTH = 3 + q2e_pkg::SQRT_STEPS + CORDIC_STAGES;

  logic adv;
  logic [DEPTH-1:0] valid_r;
  logic [DEPTH-1:0] valid_nxt;
  logic             out_valid_r;
  q2e_pkg::out_item_t out_data_r;

  // pipeline moves unless the output register is full and stalled
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // stage 1: products
  logic signed [31:0] p_wx_r, p_yz_r, p_xz_r, p_wy_r, p_xy_r, p_wz_r;
  logic signed [31:0] p_sx_r, p_sy_r, p_sz_r, p_sw_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      p_wx_r <= in_data.quat_w * in_data.quat_x;
      p_yz_r <= in_data.quat_y * in_data.quat_z;
      p_xz_r <= in_data.quat_x * in_data.quat_z;
      p_wy_r <= in_data.quat_w * in_data.quat_y;
      p_xy_r <= in_data.quat_x * in_data.quat_y;
      p_wz_r <= in_data.quat_w * in_data.quat_z;
      p_sx_r <= in_data.quat_x * in_data.quat_x;
      p_sy_r <= in_data.quat_y * in_data.quat_y;
      p_sz_r <= in_data.quat_z * in_data.quat_z;
      p_sw_r <= in_data.quat_w * in_data.quat_w;
    end
  end

  // stage 2: sums and asin argument clamp
  logic signed [33:0] t_full, yn_nxt, rn_nxt;
  logic signed [32:0] yd_nxt, rd_nxt;
  logic signed [q2e_pkg::TW-1:0] t_nxt;
  logic clamp_nxt;
  logic signed [33:0] yn_r, rn_r;
  logic signed [32:0] yd_r, rd_r;
  logic signed [q2e_pkg::TW-1:0] t_r;
  logic clamp_r;

  always_comb begin
    t_full = (34'(p_wx_r) - 34'(p_yz_r)) <<< 1;
    yn_nxt = (34'(p_xz_r) + 34'(p_wy_r)) <<< 1;
    rn_nxt = (34'(p_xy_r) + 34'(p_wz_r)) <<< 1;
    yd_nxt = 33'(p_sw_r) + 33'(p_sz_r) - 33'(p_sx_r) - 33'(p_sy_r);
    rd_nxt = 33'(p_sw_r) + 33'(p_sy_r) - 33'(p_sx_r) - 33'(p_sz_r);
    clamp_nxt = 1'b0;
    t_nxt = q2e_pkg::TW'(t_full);
    if (t_full > 34'(q2e_pkg::ONE_Q28)) begin
      t_nxt     = q2e_pkg::ONE_Q28;
      clamp_nxt = 1'b1;
    end else if (t_full < -(34'(q2e_pkg::ONE_Q28))) begin
      t_nxt     = -q2e_pkg::ONE_Q28;
      clamp_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t_r     <= t_nxt;
      clamp_r <= clamp_nxt;
      yn_r    <= yn_nxt;
      yd_r    <= yd_nxt;
      rn_r    <= rn_nxt;
      rd_r    <= rd_nxt;
    end
  end

  // stage 3: radicand 2^56 - t^2, quadrant fold for yaw and roll
  logic signed [59:0] tsq;
  q2e_pkg::sqrt_t sq_nxt;
  q2e_pkg::sqrt_t sq_r;

  always_comb begin
    tsq = t_r * t_r;
    sq_nxt.rem     = '0;
    sq_nxt.root    = '0;
    sq_nxt.rad     = q2e_pkg::RAD_W'((60'sd1 <<< 56) - tsq);
    sq_nxt.t       = t_r;
    sq_nxt.clamped = clamp_r;
    sq_nxt.yaw     = q2e_pkg::pre_rot(q2e_pkg::XW'(yd_r), q2e_pkg::XW'(yn_r));
    sq_nxt.roll    = q2e_pkg::pre_rot(q2e_pkg::XW'(rd_r), q2e_pkg::XW'(rn_r));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_r <= sq_nxt;
    end
  end

  // square-root cell row
  q2e_pkg::sqrt_t sq_chain [q2e_pkg::SQRT_STEPS+1];
  assign sq_chain[0] = sq_r;

  for (genvar i = 0; i < q2e_pkg::SQRT_STEPS; i++) begin : g_sqrt
    q2e_sqrt_cell u_cell (
      .clk  (clk),
      .en   (adv),
      .sq_i (sq_chain[i]),
      .sq_o (sq_chain[i+1])
    );
  end

  // CORDIC cell rows: pitch = atan2(t, sqrt(1 - t^2)), yaw, roll
  q2e_pkg::vec_t pv [CORDIC_STAGES+1];
  q2e_pkg::vec_t yv [CORDIC_STAGES+1];
  q2e_pkg::vec_t rv [CORDIC_STAGES+1];
  logic [CORDIC_STAGES-1:0] flag_r;

  always_comb begin
    pv[0].x = q2e_pkg::XW'(sq_chain[q2e_pkg::SQRT_STEPS].root);
    pv[0].y = q2e_pkg::XW'(sq_chain[q2e_pkg::SQRT_STEPS].t);
    pv[0].z = '0;
  end
  assign yv[0] = sq_chain[q2e_pkg::SQRT_STEPS].yaw;
  assign rv[0] = sq_chain[q2e_pkg::SQRT_STEPS].roll;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    q2e_cordic_cell #(.STAGE(i)) u_pitch (
      .clk (clk), .en (adv), .vec_i (pv[i]), .vec_o (pv[i+1])
    );
    q2e_cordic_cell #(.STAGE(i)) u_yaw (
      .clk (clk), .en (adv), .vec_i (yv[i]), .vec_o (yv[i+1])
    );
    q2e_cordic_cell #(.STAGE(i)) u_roll (
      .clk (clk), .en (adv), .vec_i (rv[i]), .vec_o (rv[i+1])
    );
  end

  // clamp flag rides beside the CORDIC rows
  always_ff @(posedge clk) begin
    if (adv) begin
      flag_r <= {flag_r[CORDIC_STAGES-2:0], sq_chain[q2e_pkg::SQRT_STEPS].clamped};
    end
  end

  // valid bits
  assign valid_nxt = {valid_r[DEPTH-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      valid_r     <= valid_nxt;
      out_valid_r <= valid_r[DEPTH-1];
    end
  end

  // output register with rounding
  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r.pitch_angle   <= q2e_pkg::to_q13(pv[CORDIC_STAGES].z);
      out_data_r.yaw_angle     <= q2e_pkg::to_q13(yv[CORDIC_STAGES].z);
      out_data_r.roll_angle    <= q2e_pkg::to_q13(rv[CORDIC_STAGES].z);
      out_data_r.pitch_clamped <= flag_r[CORDIC_STAGES-1];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a finished item in the last stage reaches the output when the pipe moves
  a_last_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv && valid_r[DEPTH-1] |=> out_valid)
    else $error("item lost between last stage and output");

  // a held pipeline keeps its occupancy
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(valid_r))
    else $error("valid bits moved while pipeline held");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk)
    rst_n && !$past(rst_n) |-> !out_valid && (valid_r == '0))
    else $error("pipeline not empty after reset");

endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for quaternion_to_euler_unit
// Random and corner quaternions go in through a valid/stall driver; a local
// fixed-point model predicts pitch, yaw, roll and the clamp flag for each item.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int STAGES  = q2e_pkg::CORDIC_STAGES_DEF;
  localparam int LATENCY = 33 + STAGES;
  localparam int N_RAND  = 1800;

  logic               clk;
  logic               rst_n;
  logic               in_valid = 1'b0;
  logic               in_stall;
  q2e_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  q2e_pkg::out_item_t out_data;

  q2e_pkg::in_item_t  pending_quats[$];
  q2e_pkg::out_item_t expected_angles[$];
  int        fail_count = 0;
  bit        stim_done = 1'b0;
  int        hold_cycles = 0;   // receiver long hold-off, counted by monitor
  bit        drain_req = 1'b0;  // sender pauses until results drained

  quaternion_to_euler_unit #(.CORDIC_STAGES(STAGES)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // clock and reset
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  // ---- angle predictor ----
  function automatic longint floor_shr(longint v, int n);
    if (v >= 0) return v >>> n;
    return ~((~v) >>> n);
  endfunction

  function automatic longint root_floor(longint unsigned n);
    longint unsigned rem, res, b;
    rem = n; res = 0; b = 64'd1 << 62;
    while (b > rem) b >>= 2;
    while (b != 0) begin
      if (rem >= res + b) begin
        rem -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint atan_step(int i);
    longint tbl [24] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
      64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
      64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
      64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
      64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
      64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
    return tbl[i];
  endfunction

  // vectoring CORDIC, angle at 2^30
  function automatic longint vector_angle(longint yv, longint xv);
    longint ang, tmp, xs, ys;
    ang = 0;
    if (xv == 0 && yv == 0) return 0;
    if (xv < 0) begin
      if (yv >= 0) begin
        tmp = xv; xv = yv; yv = -tmp; ang = 64'sd1686629713;
      end else begin
        tmp = xv; xv = -yv; yv = tmp; ang = -64'sd1686629713;
      end
    end
    for (int i = 0; i < STAGES && i < 24; i++) begin
      xs = floor_shr(xv, i);
      ys = floor_shr(yv, i);
      if (yv > 0) begin
        xv += ys; yv -= xs; ang += atan_step(i);
      end else if (yv < 0) begin
        xv -= ys; yv += xs; ang -= atan_step(i);
      end else begin
        break;
      end
    end
    return ang;
  endfunction

  function automatic logic signed [15:0] angle_q13(longint a);
    longint r;
    r = floor_shr(a + 65536, 17);
    if (r > 25736) r = 25736;
    if (r < -25736) r = -25736;
    return 16'(r);
  endfunction

  function automatic q2e_pkg::out_item_t predict_angles(q2e_pkg::in_item_t q);
    q2e_pkg::out_item_t e;
    longint x, y, z, w, t, c, one;
    x = q.quat_x; y = q.quat_y; z = q.quat_z; w = q.quat_w;
    one = 64'sd268435456;
    t = 2 * (w * x - y * z);
    e.pitch_clamped = 1'b0;
    if (t > one) begin t = one; e.pitch_clamped = 1'b1; end
    if (t < -one) begin t = -one; e.pitch_clamped = 1'b1; end
    c = root_floor(longint'(one * one - t * t));
    e.pitch_angle = angle_q13(vector_angle(t, c));
    e.yaw_angle   = angle_q13(vector_angle(2 * (x * z + w * y),
                                           w*w + z*z - x*x - y*y));
    e.roll_angle  = angle_q13(vector_angle(2 * (x * y + w * z),
                                           w*w + y*y - x*x - z*z));
    return e;
  endfunction

  function automatic q2e_pkg::in_item_t mk_quat(int x, int y, int z, int w);
    q2e_pkg::in_item_t q;
    q.quat_x = 16'(x); q.quat_y = 16'(y); q.quat_z = 16'(z); q.quat_w = 16'(w);
    return q;
  endfunction

  // roughly unit quaternion with random direction
  function automatic q2e_pkg::in_item_t unit_quat();
    real a, b, c, d, n;
    a = real'($urandom_range(0, 20000)) - 10000.0;
    b = real'($urandom_range(0, 20000)) - 10000.0;
    c = real'($urandom_range(0, 20000)) - 10000.0;
    d = real'($urandom_range(0, 20000)) - 10000.0;
    n = $sqrt(a*a + b*b + c*c + d*d);
    if (n < 1.0) return mk_quat(0, 0, 0, 16384);
    return mk_quat(int'(a * 16384.0 / n), int'(b * 16384.0 / n),
                   int'(c * 16384.0 / n), int'(d * 16384.0 / n));
  endfunction

  // ---- stimulus ----
  initial begin
    int mx, mn;
    mx = 32767; mn = -32768;
    // directed corners
    pending_quats.push_back(mk_quat(0, 0, 0, 0));          // both atan2 args zero
    pending_quats.push_back(mk_quat(0, 0, 0, 16384));      // identity
    pending_quats.push_back(mk_quat(16384, 0, 0, 0));      // left half plane
    pending_quats.push_back(mk_quat(0, 16384, 0, 0));
    pending_quats.push_back(mk_quat(0, 0, 16384, 0));
    pending_quats.push_back(mk_quat(11585, 0, 0, 11585));  // pitch at +1
    pending_quats.push_back(mk_quat(-11585, 0, 0, 11585)); // pitch at -1
    pending_quats.push_back(mk_quat(mx, mx, mx, mx));      // full scale, asin argument cancels to zero
    pending_quats.push_back(mk_quat(mn, mn, mn, mn));
    pending_quats.push_back(mk_quat(mx, mn, mx, mn));
    pending_quats.push_back(mk_quat(mn, mx, mn, mx));
    pending_quats.push_back(mk_quat(mx, 0, 0, mx));
    pending_quats.push_back(mk_quat(mn, 0, 0, mx));
    pending_quats.push_back(mk_quat(0, mx, mx, 0));
    pending_quats.push_back(mk_quat(0, 0, 0, mn));
    pending_quats.push_back(mk_quat(-16384, 0, 0, 0));
    pending_quats.push_back(mk_quat(0, -16384, 0, -1));
    pending_quats.push_back(mk_quat(0, 0, -16384, -1));
    pending_quats.push_back(mk_quat(1, 0, 0, -1));
    pending_quats.push_back(mk_quat(0, -1, 0, 0));
    for (int i = 0; i < N_RAND; i++) begin
      if ($urandom_range(0, 3) == 0)
        pending_quats.push_back(mk_quat($urandom_range(0, 65535), $urandom_range(0, 65535),
                                        $urandom_range(0, 65535), $urandom_range(0, 65535)));
      else
        pending_quats.push_back(unit_quat());
    end
  end

  // ---- driver ----
  int gap_left = 0;
  int sent_count = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_angles.push_back(predict_angles(in_data));
        sent_count <= sent_count + 1;
        if (sent_count + 1 == 900) drain_req <= 1'b1;
      end
      if (in_valid && in_stall) begin
        // hold item
      end else if (drain_req && (expected_angles.size() != 0 || in_valid)) begin
        in_valid <= 1'b0;
      end else if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_quats.size() != 0) begin
        if (drain_req) drain_req <= 1'b0;
        in_valid <= 1'b1;
        in_data <= pending_quats.pop_front();
        gap_left <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 9) : 0;
      end else begin
        in_valid <= 1'b0;
        stim_done <= 1'b1;
      end
    end
  end

  // ---- monitor ----
  int stall_left = 0;
  int recv_count = 0;

  always @(posedge clk) begin
    q2e_pkg::out_item_t e;
    int bad;
    bad = 0;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        recv_count <= recv_count + 1;
        if (expected_angles.size() == 0) begin
          $error("result with nothing expected");
          bad++;
        end else begin
          e = expected_angles.pop_front();
          if (out_data.pitch_angle !== e.pitch_angle) begin
            $error("pitch_angle exp %0d got %0d", e.pitch_angle, out_data.pitch_angle);
            bad++;
          end
          if (out_data.yaw_angle !== e.yaw_angle) begin
            $error("yaw_angle exp %0d got %0d", e.yaw_angle, out_data.yaw_angle);
            bad++;
          end
          if (out_data.roll_angle !== e.roll_angle) begin
            $error("roll_angle exp %0d got %0d", e.roll_angle, out_data.roll_angle);
            bad++;
          end
          if (out_data.pitch_clamped !== e.pitch_clamped) begin
            $error("pitch_clamped exp %0d got %0d", e.pitch_clamped, out_data.pitch_clamped);
            bad++;
          end
        end
        if (bad != 0) fail_count <= fail_count + bad;
      end
      // long hold-off once, early in the random part
      if (recv_count == 300 && hold_cycles == 0) begin
        hold_cycles <= 200;
        out_stall <= 1'b1;
      end else if (hold_cycles > 1) begin
        hold_cycles <= hold_cycles - 1;
      end else if (hold_cycles == 1) begin
        hold_cycles <= -1;
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else if (out_valid && !out_stall && $urandom_range(0, 2) == 0) begin
        stall_left <= $urandom_range(0, 9);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---- end of run ----
  initial begin
    @(posedge rst_n);
    wait (stim_done && expected_angles.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0 && expected_angles.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
